@@ sv/tbs_pkg.sv @@
// shared types, constants and helper functions of the two-bone skinning block
`timescale 1ns / 1ps
`default_nettype none
package tbs_pkg;

    localparam int MAX_BONES_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORDS_PER_BONE = 12;
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // divide by one hundred: floor(m * RECIP_100 / 2^RECIP_SH) is low by at most one
    localparam int DIV_MAG_W = 38;
    localparam int RECIP_SH = 38;
    localparam logic [31:0] RECIP_100 = 32'd2748779069;

    localparam logic [1:0] CFG_BONE_COUNT = 2'd0;
    localparam logic [1:0] CFG_EDGE_DIST = 2'd1;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_SKIN = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [15:0]        bone_first;
        logic [15:0]        bone_second;
        logic [6:0]         weight_percent;
        logic [3:0]         word_select;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic               edge_off;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] skin_x;
        logic signed [31:0] skin_y;
        logic signed [31:0] skin_z;
        logic signed [31:0] norm_out_x;
        logic signed [31:0] norm_out_y;
        logic signed [31:0] norm_out_z;
        logic signed [31:0] edge_x;
        logic signed [31:0] edge_y;
        logic signed [31:0] edge_z;
    } t_out_item;

    // one classified vertex with both bone matrices already fetched
    typedef struct packed {
        logic [1:0]                            bone_ok;
        logic [6:0]                            weight;
        logic [31:0]                           amount;
        logic [2:0][31:0]                      pos;
        logic [2:0][31:0]                      nrm;
        logic [1:0][WORDS_PER_BONE-1:0][31:0]  mat;
    } t_q_item;

    typedef struct packed {
        logic               valid;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned f);
        logic signed [63:0] half;
        half = 64'sd1 <<< (f - 1);
        return (v + half) >>> f;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/tbs_stream_if.sv @@
// valid/ready stream channel carrying one payload item per transfer
`timescale 1ns / 1ps
`default_nettype none
interface tbs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/two_bone_vertex_skinning.sv @@
// top level of the two-bone vertex skinning block
//
//  channel   dir  payload     transfer means
//  i_vtx     in   t_in_item   palette word write or one vertex
//  o_res     out  t_out_item  skinned position, normal and edge point
//  i_cfg_*   in   32b word    bone_count (index 0) or edge_distance (index 1)
//
// one item is taken per cycle while the queue has room, palette writes and vertices alike
// a vertex result is offered after the fetch register, the queue write and eight back stages
// the twelve palette banks are read at both bone indices in the fetch cycle
// reset clears config registers and control; the palette is undefined until written
// a stalled output freezes the back pipeline; the queue keeps the front accepting until it is full
`timescale 1ns / 1ps
`default_nettype none
module two_bone_vertex_skinning #(
    parameter int MAX_BONES = tbs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_idx,
    input  wire [31:0]   i_cfg_data,
    tbs_stream_if.sink   i_vtx,
    tbs_stream_if.source o_res
);
    import tbs_pkg::*;

    // front to queue
    logic    w_push;
    t_q_item w_push_data;
    // queue to back
    logic    w_pop;
    t_q_item w_head;
    t_q_stat w_qstat;

    tbs_front #(
        .MAX_BONES(MAX_BONES),
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (i_vtx),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_data     (w_push_data)
    );

    // decouples classification from the arithmetic pipeline
    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_qstat)
    );

    tbs_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (w_head),
        .i_qstat  (w_qstat),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );
endmodule
`default_nettype wire

@@ sv/tbs_queue.sv @@
// short flop queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module tbs_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  tbs_pkg::t_q_item      i_data,
    input  wire                   i_pop,
    output tbs_pkg::t_q_item      o_data,
    output tbs_pkg::t_q_stat      o_stat
);
    import tbs_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_q_item            r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wptr = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == Q_CNT_W'(Q_DEPTH)))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue underflow");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
endmodule
`default_nettype wire

@@ sv/tbs_front.sv @@
// front part: config registers, palette banks, vertex classification and fetch
`timescale 1ns / 1ps
`default_nettype none
module tbs_front #(
    parameter int MAX_BONES = tbs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_idx,
    input  wire [31:0]          i_cfg_data,
    tbs_stream_if.sink          i_vtx,
    input  tbs_pkg::t_q_stat    i_qstat,
    output logic                o_push,
    output tbs_pkg::t_q_item    o_data
);
    import tbs_pkg::*;

    localparam int IDX_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam logic signed [31:0] FIX_AMOUNT =
        32'(-(((5 << FRAC_BITS) + 500) / 1000));

    logic [8:0]  r_bone_count;
    logic [31:0] r_edge_dist;
    logic        r_f1_valid;
    t_q_item     r_f1;
    logic        w_take;
    logic        w_is_skin;
    logic        w_wr_ok;
    logic [1:0]  w_bone_ok;
    t_in_item    w_in;

    assign w_in = i_vtx.payload;
    // one slot is kept free for the item already in the fetch stage
    assign i_vtx.ready = ({1'b0, i_qstat.count} + Q_CNT_W'(r_f1_valid)) <
                         (Q_CNT_W + 1)'(Q_DEPTH);
    assign w_take = i_vtx.valid && i_vtx.ready;
    assign w_is_skin = (w_in.mode == MODE_SKIN);
    assign w_wr_ok = (w_in.bone_first < 16'(MAX_BONES)) &&
                     (w_in.word_select < 4'(WORDS_PER_BONE));
    assign w_bone_ok[0] = (w_in.bone_first < {7'd0, r_bone_count}) &&
                          (w_in.bone_first < 16'(MAX_BONES));
    assign w_bone_ok[1] = (w_in.bone_second < {7'd0, r_bone_count}) &&
                          (w_in.bone_second < 16'(MAX_BONES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= '0;
            r_edge_dist <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BONE_COUNT: r_bone_count <= i_cfg_data[8:0];
                CFG_EDGE_DIST:  r_edge_dist <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_take && w_is_skin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_f1.bone_ok <= w_bone_ok;
            r_f1.weight <= (w_in.weight_percent > 7'd100) ? 7'd100 : w_in.weight_percent;
            r_f1.amount <= w_in.edge_off ? FIX_AMOUNT : r_edge_dist;
            r_f1.pos <= {w_in.pos_z, w_in.pos_y, w_in.pos_x};
            r_f1.nrm <= {w_in.nrm_z, w_in.nrm_y, w_in.nrm_x};
        end
    end

    // one bank per matrix word, each with one write and two read addresses
    for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_bank
        logic [31:0] r_bank [MAX_BONES];
        logic [31:0] r_rd0, r_rd1;
        always_ff @(posedge i_clk) begin
            if (w_take && !w_is_skin && w_wr_ok && w_in.word_select == 4'(k)) begin
                r_bank[w_in.bone_first[IDX_W-1:0]] <= w_in.pos_x;
            end
            if (w_take && w_is_skin) begin
                r_rd0 <= r_bank[w_in.bone_first[IDX_W-1:0]];
                r_rd1 <= r_bank[w_in.bone_second[IDX_W-1:0]];
            end
        end
        assign o_data.mat[0][k] = r_rd0;
        assign o_data.mat[1][k] = r_rd1;
    end

    assign o_push = r_f1_valid;
    assign o_data.bone_ok = r_f1.bone_ok;
    assign o_data.weight = r_f1.weight;
    assign o_data.amount = r_f1.amount;
    assign o_data.pos = r_f1.pos;
    assign o_data.nrm = r_f1.nrm;
endmodule
`default_nettype wire

@@ sv/tbs_back.sv @@
// back part: transform, blend, divide by one hundred, edge offset, output register
`timescale 1ns / 1ps
`default_nettype none
module tbs_back #(
    parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tbs_pkg::t_q_item    i_q_data,
    input  tbs_pkg::t_q_stat    i_qstat,
    output logic                o_pop,
    tbs_stream_if.source        o_res
);
    import tbs_pkg::*;

    localparam int NST = 8;

    logic [NST-1:0] r_v;
    logic           w_adv;

    // stage 1: products
    logic signed [63:0] r_pp [2][3][3];
    logic signed [63:0] r_pn [2][3][3];
    logic signed [31:0] r_tr1 [2][3];
    logic [1:0]         r_ok1;
    logic [6:0]         r_wt1, r_wt2;
    logic [31:0]        r_am1, r_am2, r_am3, r_am4, r_am5, r_am6;
    // stage 2: per-bone transforms, lanes 0..2 position, 3..5 normal
    logic signed [63:0] r_x [2][6];
    // stage 3: blend numerators
    logic signed [63:0] r_num [6];
    // stage 4: magnitudes
    logic [DIV_MAG_W-1:0] r_m4 [6], r_m5 [6];
    logic [5:0]           r_neg4, r_neg5, r_big4, r_big5;
    // stage 5: quotient estimates
    logic [31:0]        r_q0 [6];
    // stage 6: blended values
    logic signed [31:0] r_bl [6];
    logic signed [31:0] r_sk7 [3];
    // stage 7: edge products
    logic signed [63:0] r_ep [3];
    t_out_item          r_out;

    assign w_adv = !r_v[NST-1] || o_res.ready;
    assign o_pop = w_adv && i_qstat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NST-2:0], i_qstat.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int b = 0; b < 2; b++) begin
                for (int a = 0; a < 3; a++) begin
                    for (int i = 0; i < 3; i++) begin
                        r_pp[b][a][i] <= $signed(i_q_data.pos[i]) *
                                         $signed(i_q_data.mat[b][a*4+i]);
                        r_pn[b][a][i] <= $signed(i_q_data.nrm[i]) *
                                         $signed(i_q_data.mat[b][a*4+i]);
                    end
                    r_tr1[b][a] <= $signed(i_q_data.mat[b][a*4+3]);
                end
            end
            r_ok1 <= i_q_data.bone_ok;
            r_wt1 <= i_q_data.weight;
            r_am1 <= i_q_data.amount;

            for (int b = 0; b < 2; b++) begin
                for (int a = 0; a < 3; a++) begin
                    r_x[b][a] <= r_ok1[b] ?
                        rnd_shift(r_pp[b][a][0], FRAC_BITS) +
                        rnd_shift(r_pp[b][a][1], FRAC_BITS) +
                        rnd_shift(r_pp[b][a][2], FRAC_BITS) +
                        64'(r_tr1[b][a]) : 64'sd0;
                    r_x[b][a+3] <= r_ok1[b] ?
                        rnd_shift(r_pn[b][a][0], FRAC_BITS) +
                        rnd_shift(r_pn[b][a][1], FRAC_BITS) +
                        rnd_shift(r_pn[b][a][2], FRAC_BITS) : 64'sd0;
                end
            end
            r_wt2 <= r_wt1;
            r_am2 <= r_am1;

            for (int l = 0; l < 6; l++) begin
                r_num[l] <= r_x[0][l] * $signed({1'b0, r_wt2}) +
                            r_x[1][l] * $signed({1'b0, 7'd100 - r_wt2});
            end
            r_am3 <= r_am2;

            for (int l = 0; l < 6; l++) begin
                logic [63:0] mag;
                mag = (r_num[l] < 0) ? 64'(-r_num[l]) + 64'd50 : 64'(r_num[l]) + 64'd50;
                r_neg4[l] <= r_num[l] < 0;
                // at or above 2^38 the quotient is beyond the signed 32-bit range
                r_big4[l] <= (mag[63:DIV_MAG_W] != '0);
                r_m4[l] <= mag[DIV_MAG_W-1:0];
            end
            r_am4 <= r_am3;

            for (int l = 0; l < 6; l++) begin
                logic [DIV_MAG_W+31:0] prod;
                prod = (DIV_MAG_W + 32)'(r_m4[l]) * (DIV_MAG_W + 32)'(RECIP_100);
                r_q0[l] <= prod[RECIP_SH+31:RECIP_SH];
                r_m5[l] <= r_m4[l];
            end
            r_neg5 <= r_neg4;
            r_big5 <= r_big4;
            r_am5 <= r_am4;

            for (int l = 0; l < 6; l++) begin
                logic [DIV_MAG_W+1:0] rem;
                logic [32:0]          q;
                logic signed [63:0]   sv;
                rem = (DIV_MAG_W + 2)'(r_m5[l]) - (DIV_MAG_W + 2)'(r_q0[l]) *
                      (DIV_MAG_W + 2)'(100);
                q = {1'b0, r_q0[l]} + 33'(rem >= (DIV_MAG_W + 2)'(100));
                sv = r_neg5[l] ? -$signed(64'(q)) : $signed(64'(q));
                if (r_big5[l]) begin
                    r_bl[l] <= r_neg5[l] ? 32'sh80000000 : 32'sh7fffffff;
                end else begin
                    r_bl[l] <= sat32(sv);
                end
            end
            r_am6 <= r_am5;

            for (int a = 0; a < 3; a++) begin
                r_ep[a] <= r_bl[a+3] * $signed(r_am6);
                r_sk7[a] <= r_bl[a];
            end
            r_out.norm_out_x <= r_bl[3];
            r_out.norm_out_y <= r_bl[4];
            r_out.norm_out_z <= r_bl[5];

            r_out.skin_x <= r_sk7[0];
            r_out.skin_y <= r_sk7[1];
            r_out.skin_z <= r_sk7[2];
            r_out.edge_x <= sat32(64'(r_sk7[0]) + rnd_shift(r_ep[0], FRAC_BITS));
            r_out.edge_y <= sat32(64'(r_sk7[1]) + rnd_shift(r_ep[1], FRAC_BITS));
            r_out.edge_z <= sat32(64'(r_sk7[2]) + rnd_shift(r_ep[2], FRAC_BITS));
        end
    end

    // the normal is taken one stage early, so hold it in step with the output
    t_out_item w_out;
    logic signed [31:0] r_nh [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nh[0] <= r_out.norm_out_x;
            r_nh[1] <= r_out.norm_out_y;
            r_nh[2] <= r_out.norm_out_z;
        end
    end
    always_comb begin
        w_out = r_out;
        w_out.norm_out_x = r_nh[0];
        w_out.norm_out_y = r_nh[1];
        w_out.norm_out_z = r_nh[2];
    end

    assign o_res.valid = r_v[NST-1];
    assign o_res.payload = w_out;
endmodule
`default_nettype wire

@@ bench/skin_checker.sv @@
// watches the skinning block channels, predicts each vertex result and compares it
`timescale 1ns / 1ps
`default_nettype none
module skin_checker
    import tbs_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data,
    input  wire        i_vtx_valid,
    input  wire        i_vtx_ready,
    input  t_in_item   i_vtx_item,
    input  wire        i_res_valid,
    input  wire        i_res_ready,
    input  t_out_item  i_res_item,
    output int         o_fail_count,
    output int         o_pending
);

    // fixed edge offset used when edges are off: -round(0.005 * 2^16)
    localparam logic signed [63:0] EDGE_OFF_AMOUNT = -64'sd328;

    logic [31:0]        palette_words [MAX_BONES * WORDS_PER_BONE];
    logic [8:0]         bone_cnt;
    logic signed [31:0] edge_dist;
    t_out_item          expected_results [$];

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] prod;
        prod = a * b;
        return (prod + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int bone_base(input logic [15:0] idx);
        if (idx >= bone_cnt || idx >= MAX_BONES) return -1;
        return int'(idx) * WORDS_PER_BONE;
    endfunction

    // one output axis of a bone transform, translation only for positions
    function automatic logic signed [63:0] bone_axis(input logic signed [63:0] v [3],
                                                     input int base, input int axis,
                                                     input bit with_trans);
        logic signed [63:0] acc;
        acc = 0;
        if (base < 0) return 0;
        for (int i = 0; i < 3; i++)
            acc += fx_mul(v[i], 64'(signed'(palette_words[base + axis * 4 + i])));
        if (with_trans)
            acc += 64'(signed'(palette_words[base + axis * 4 + 3]));
        return acc;
    endfunction

    // weighted mix rounded half away from zero
    function automatic logic signed [63:0] weight_mix(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic signed [63:0] pct);
        logic signed [63:0] num;
        num = a * pct + b * (64'sd100 - pct);
        if (num >= 0) return clip32((num + 64'sd50) / 64'sd100);
        return clip32(-((-num + 64'sd50) / 64'sd100));
    endfunction

    function automatic t_out_item skin_vertex(input t_in_item it);
        logic signed [63:0] pos [3];
        logic signed [63:0] nrm [3];
        logic signed [63:0] sk [3];
        logic signed [63:0] nr [3];
        logic signed [63:0] edge_pt [3];
        logic signed [63:0] pct, amount;
        int b0, b1;
        t_out_item r;
        b0 = bone_base(it.bone_first);
        b1 = bone_base(it.bone_second);
        pct = (it.weight_percent > 7'd100) ? 64'sd100 : 64'(it.weight_percent);
        pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
        nrm[0] = it.nrm_x; nrm[1] = it.nrm_y; nrm[2] = it.nrm_z;
        amount = it.edge_off ? EDGE_OFF_AMOUNT : 64'(edge_dist);
        for (int c = 0; c < 3; c++) begin
            sk[c] = weight_mix(bone_axis(pos, b0, c, 1'b1), bone_axis(pos, b1, c, 1'b1), pct);
            nr[c] = weight_mix(bone_axis(nrm, b0, c, 1'b0), bone_axis(nrm, b1, c, 1'b0), pct);
            edge_pt[c] = clip32(sk[c] + fx_mul(nr[c], amount));
        end
        r.skin_x = sk[0][31:0]; r.skin_y = sk[1][31:0]; r.skin_z = sk[2][31:0];
        r.norm_out_x = nr[0][31:0]; r.norm_out_y = nr[1][31:0]; r.norm_out_z = nr[2][31:0];
        r.edge_x = edge_pt[0][31:0]; r.edge_y = edge_pt[1][31:0];
        r.edge_z = edge_pt[2][31:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        string names [9];
        names = '{"skin_x", "skin_y", "skin_z", "norm_out_x", "norm_out_y",
                  "norm_out_z", "edge_x", "edge_y", "edge_z"};
        if (!i_rst_n) begin
            bone_cnt = '0;
            edge_dist = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BONE_COUNT) bone_cnt = i_cfg_data[8:0];
                else if (i_cfg_idx == CFG_EDGE_DIST) edge_dist = i_cfg_data;
            end
            if (i_vtx_valid && i_vtx_ready) begin
                if (i_vtx_item.mode == MODE_PALETTE) begin
                    if (i_vtx_item.bone_first < MAX_BONES &&
                        i_vtx_item.word_select < WORDS_PER_BONE)
                        palette_words[int'(i_vtx_item.bone_first) * WORDS_PER_BONE +
                                      int'(i_vtx_item.word_select)] = i_vtx_item.pos_x;
                end else begin
                    expected_results.push_back(skin_vertex(i_vtx_item));
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: %h",
                             $time, i_res_item);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    // fields sit in declaration order, skin_x at the top
                    for (int f = 0; f < 9; f++) begin
                        if (want[(8 - f) * 32 +: 32] !== i_res_item[(8 - f) * 32 +: 32]) begin
                            $display("%0t: %s expected %h actual %h", $time, names[f],
                                     want[(8 - f) * 32 +: 32], i_res_item[(8 - f) * 32 +: 32]);
                            o_fail_count++;
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule
`default_nettype wire

@@ bench/two_bone_vertex_skinning_tb.sv @@
// stimulus and verdict for the two-bone vertex skinning block
`timescale 1ns / 1ps
`default_nettype none
module two_bone_vertex_skinning_tb;
    import tbs_pkg::*;

    localparam int NUM_BONES = 256;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    tbs_stream_if #(.T(t_in_item))  vtx_if ();
    tbs_stream_if #(.T(t_out_item)) res_if ();

    two_bone_vertex_skinning dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vtx      (vtx_if),
        .o_res      (res_if)
    );

    skin_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_vtx_valid  (vtx_if.valid),
        .i_vtx_ready  (vtx_if.ready),
        .i_vtx_item   (vtx_if.payload),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_item   (res_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // stall knobs, changed per phase
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_tag;
    int         hold_seen;
    int         hold_left;
    // which palette words have been written, so no vertex reads an unwritten bone
    logic [11:0] words_written [NUM_BONES];
    logic [8:0]  cur_bone_count;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end else begin
            if (hold_seen != hold_tag) begin
                hold_seen = hold_tag;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // mostly moderate values so that not every result saturates
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2, 3: return $urandom;
            default: return 32'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
        endcase
    endfunction

    // matrix words mostly within about two units of zero
    function automatic logic [31:0] rand_coeff();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return 32'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
    endfunction

    function automatic t_in_item rand_item();
        logic [319:0] raw;
        t_in_item it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.pos_x = rand_value(); it.pos_y = rand_value(); it.pos_z = rand_value();
        it.nrm_x = rand_value(); it.nrm_y = rand_value(); it.nrm_z = rand_value();
        return it;
    endfunction

    // a fully written bone below the count, or an index that selects the zero matrix
    function automatic logic [15:0] pick_bone();
        int usable [$];
        for (int b = 0; b < cur_bone_count && b < NUM_BONES; b++)
            if (&words_written[b]) usable.push_back(b);
        if (usable.size() == 0 || $urandom_range(0, 4) == 0)
            return 16'($urandom_range(cur_bone_count, 65535));
        return 16'(usable[$urandom_range(0, usable.size() - 1)]);
    endfunction

    function automatic t_in_item vertex_item();
        t_in_item it;
        it = rand_item();
        it.mode = MODE_SKIN;
        it.bone_first = pick_bone();
        it.bone_second = pick_bone();
        if ($urandom_range(0, 3) == 0) it.weight_percent = 7'($urandom_range(95, 127));
        return it;
    endfunction

    function automatic t_in_item palette_item(input int bone, input int word,
                                              input logic [31:0] value);
        t_in_item it;
        it = rand_item();
        it.mode = MODE_PALETTE;
        it.bone_first = 16'(bone);
        it.word_select = 4'(word);
        it.pos_x = value;
        return it;
    endfunction

    // one transfer on the vertex channel, then an optional random gap
    task automatic send_item(input t_in_item it);
        vtx_if.valid <= 1'b1;
        vtx_if.payload <= it;
        do @(negedge i_clk); while (!vtx_if.ready);
        @(posedge i_clk);
        if (it.mode == MODE_PALETTE && it.bone_first < NUM_BONES &&
            it.word_select < WORDS_PER_BONE)
            words_written[it.bone_first[7:0]][it.word_select] = 1'b1;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            vtx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // one write cycle, then the strobe is dropped again before the task returns
    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BONE_COUNT) cur_bone_count = value[8:0];
        @(posedge i_clk);
    endtask

    // wait for every expected result, then let the pipeline drain
    task automatic drain();
        vtx_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic load_bone(input int bone, input bit extreme);
        for (int w = 0; w < WORDS_PER_BONE; w++)
            send_item(palette_item(bone, w, extreme ? (w[0] ? 32'h80000000 : 32'h7fffffff)
                                                    : rand_coeff()));
    endtask

    task automatic random_phase(input int n_items, input int idle, input int stall,
                                input bit pressure);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < n_items; n++) begin
            if (pressure && n == 40) hold_tag++;
            if (pressure && n == 200) begin
                // sender pauses until every result is back
                vtx_if.valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
                @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                send_item(vertex_item());
            end else if ($urandom_range(0, 4) == 0) begin
                // random entry and word, mostly out of range and then ignored by the block
                send_item(palette_item($urandom_range(0, 65535), $urandom_range(0, 15),
                                       $urandom));
            end else begin
                send_item(palette_item($urandom_range(0, NUM_BONES - 1),
                                       $urandom_range(0, WORDS_PER_BONE - 1), rand_coeff()));
            end
        end
        drain();
    endtask

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        vtx_if.valid = 1'b0;
        vtx_if.payload = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_tag = 0;
        cur_bone_count = '0;
        for (int b = 0; b < NUM_BONES; b++) words_written[b] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cfg(CFG_BONE_COUNT, 32'd10);
        write_cfg(CFG_EDGE_DIST, 32'h00008000);

        // palette set-up: ordinary bones, one bone of extreme words, top entries
        for (int b = 0; b < 9; b++) load_bone(b, 1'b0);
        load_bone(9, 1'b1);
        for (int b = 250; b < NUM_BONES; b++) load_bone(b, 1'b0);

        // directed vertices: weights at and past the limit, bad indices, extremes
        it = vertex_item(); it.bone_first = 0; it.bone_second = 1;
        it.weight_percent = 0; it.edge_off = 0; send_item(it);
        it.weight_percent = 100; it.edge_off = 1; send_item(it);
        it.weight_percent = 101; send_item(it);
        it.weight_percent = 127; it.edge_off = 0; send_item(it);
        it.weight_percent = 50; it.bone_first = 10; send_item(it);
        it.bone_first = 3; it.bone_second = 16'hffff; send_item(it);
        it.bone_first = 255; it.bone_second = 256; send_item(it);
        it.weight_percent = 33;
        it.pos_x = 32'h7fffffff; it.pos_y = 32'h7fffffff; it.pos_z = 32'h7fffffff;
        it.nrm_x = 32'h80000000; it.nrm_y = 32'h80000000; it.nrm_z = 32'h80000000;
        it.bone_first = 9; it.bone_second = 9; send_item(it);
        it.edge_off = 1; it.bone_second = 2; send_item(it);
        it.pos_x = 32'h80000000; it.pos_y = 32'h80000000; it.pos_z = 32'h80000000;
        it.nrm_x = 32'h7fffffff; it.nrm_y = 32'h7fffffff; it.nrm_z = 32'h7fffffff;
        it.weight_percent = 67; send_item(it);
        it.pos_x = 0; it.pos_y = 0; it.pos_z = 0; it.nrm_x = 0; it.nrm_y = 0; it.nrm_z = 0;
        send_item(it);
        // ignored palette writes must not disturb bone 0
        send_item(palette_item(256, 0, 32'hdeadbeef));
        send_item(palette_item(65535, 3, 32'h12345678));
        send_item(palette_item(0, 12, 32'h7fffffff));
        send_item(palette_item(0, 15, 32'h80000000));
        it = vertex_item(); it.bone_first = 0; it.bone_second = 0; send_item(it);
        drain();

        write_cfg(CFG_BONE_COUNT, 32'd10);
        write_cfg(CFG_EDGE_DIST, 32'h00008000);
        random_phase(320, 0, 0, 1'b1);

        write_cfg(CFG_BONE_COUNT, 32'd0);
        write_cfg(CFG_EDGE_DIST, 32'h80000000);
        random_phase(250, 45, 0, 1'b0);

        write_cfg(CFG_BONE_COUNT, 32'd256);
        write_cfg(CFG_EDGE_DIST, 32'h7fffffff);
        random_phase(320, 0, 45, 1'b0);

        write_cfg(CFG_BONE_COUNT, 32'($urandom_range(1, 12)));
        write_cfg(CFG_EDGE_DIST, $urandom);
        random_phase(320, 14, 14, 1'b0);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
